[design/vwk_pkg.sv]
// Shared types and codes for the vehicle bus wake controller.
package vwk_pkg;

	localparam int RunMax = 3;

	localparam logic [1:0] MODE_ASLEEP   = 2'd0;
	localparam logic [1:0] MODE_WAKE_REQ = 2'd1;
	localparam logic [1:0] MODE_WAKING   = 2'd2;
	localparam logic [1:0] MODE_AWAKE    = 2'd3;

	localparam logic [1:0] FRAME_NONE      = 2'd0;
	localparam logic [1:0] FRAME_WAKE      = 2'd1;
	localparam logic [1:0] FRAME_INIT      = 2'd2;
	localparam logic [1:0] FRAME_KEEPALIVE = 2'd3;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_ENSURE  = 2'd1;
	localparam logic [1:0] OP_REQUEST = 2'd2;
	localparam logic [1:0] OP_COMMAND = 2'd3;

	localparam logic [1:0] REG_KA_INTERVAL = 2'd0;
	localparam logic [1:0] REG_KA_TIMEOUT  = 2'd1;
	localparam logic [1:0] REG_WAKE_LIMIT  = 2'd2;
	localparam logic [1:0] REG_INIT_WAIT   = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] now_ms;
		logic        bus_activity;
		logic        tx_ok;
		logic        init_tx_ok;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  frame_kind;
		logic        last_of_run;
		logic [1:0]  wake_status;
		logic        keepalive_on;
		logic [31:0] attempt_count;
		logic [31:0] failure_count;
		logic [31:0] keepalive_count;
	} out_item_t;

	typedef struct packed {
		logic [15:0] ka_interval;
		logic [31:0] ka_timeout;
		logic [31:0] wake_limit;
		logic [31:0] init_wait;
	} cfg_regs_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        ka_active;
		logic [31:0] last_ka_time;
		logic [31:0] last_cmd_time;
		logic [31:0] mode_entry;
		logic [31:0] attempts;
		logic [31:0] failures;
		logic [31:0] ka_sent;
	} wake_state_t;

	typedef struct packed {
		logic [RunMax-1:0][1:0] kinds;
		logic [1:0]             len;
	} run_t;

endpackage

[design/vwk_step.sv]
// Next-state and frame-run logic for one event of the wake controller.
module vwk_step (
	input  vwk_pkg::wake_state_t st,
	input  vwk_pkg::cfg_regs_t   cfg,
	input  vwk_pkg::in_item_t    item,
	output vwk_pkg::wake_state_t st_n,
	output vwk_pkg::run_t        run
);
	import vwk_pkg::*;

	logic [31:0] now;
	logic [31:0] elapsed;
	logic [31:0] cmd_idle;
	logic [31:0] ka_age;
	logic [RunMax-1:0][1:0] kinds;
	logic [1:0] cnt;

	assign now      = item.now_ms;
	assign elapsed  = now - st.mode_entry;
	assign cmd_idle = now - st.last_cmd_time;
	assign ka_age   = now - st.last_ka_time;

	always_comb begin
		st_n  = st;
		kinds = {RunMax{FRAME_NONE}};
		cnt   = 2'd0;
		unique case (item.op)
			OP_TICK: begin
				if (st.ka_active) begin
					if (cmd_idle > cfg.ka_timeout)
						st_n.ka_active = 1'b0;
					if (ka_age >= {16'd0, cfg.ka_interval}) begin
						kinds[cnt] = FRAME_KEEPALIVE;
						cnt = cnt + 2'd1;
						if (item.tx_ok)
							st_n.ka_sent = st_n.ka_sent + 32'd1;
						st_n.last_ka_time = now;
					end
				end
				unique case (st.mode)
					MODE_ASLEEP: begin
						if (item.bus_activity) begin
							st_n.mode = MODE_AWAKE;
							st_n.mode_entry = now;
						end
					end
					MODE_WAKE_REQ: begin
						kinds[cnt] = FRAME_WAKE;
						cnt = cnt + 2'd1;
						st_n.mode_entry = now;
						if (!item.tx_ok) begin
							st_n.mode = MODE_ASLEEP;
							st_n.failures = st_n.failures + 32'd1;
						end else begin
							if (!st_n.ka_active) begin
								st_n.ka_active = 1'b1;
								st_n.last_ka_time = now;
								st_n.last_cmd_time = now;
								st_n.ka_sent = st_n.ka_sent + 32'd1;
								if (cnt != 2'd3) begin
									kinds[cnt] = FRAME_KEEPALIVE;
									cnt = cnt + 2'd1;
								end
							end
							if (cnt != 2'd3) begin
								kinds[cnt] = FRAME_INIT;
								cnt = cnt + 2'd1;
							end
							if (!item.init_tx_ok) begin
								st_n.ka_active = 1'b0;
								st_n.mode = MODE_ASLEEP;
								st_n.failures = st_n.failures + 32'd1;
							end else begin
								st_n.mode = MODE_WAKING;
							end
						end
					end
					MODE_WAKING: begin
						if (item.bus_activity) begin
							if (elapsed >= cfg.init_wait) begin
								st_n.mode = MODE_AWAKE;
								st_n.mode_entry = now;
							end
						end else if (elapsed > cfg.wake_limit) begin
							st_n.ka_active = 1'b0;
							st_n.mode = MODE_ASLEEP;
							st_n.mode_entry = now;
							st_n.failures = st_n.failures + 32'd1;
						end
					end
					MODE_AWAKE: begin
						if (!item.bus_activity) begin
							st_n.ka_active = 1'b0;
							st_n.mode = MODE_ASLEEP;
							st_n.mode_entry = now;
						end
					end
				endcase
			end
			OP_ENSURE, OP_COMMAND: begin
				st_n.last_cmd_time = now;
				if (st.mode == MODE_AWAKE && !st.ka_active) begin
					st_n.ka_active = 1'b1;
					st_n.last_ka_time = now;
					kinds[cnt] = FRAME_KEEPALIVE;
					cnt = cnt + 2'd1;
					if (item.tx_ok)
						st_n.ka_sent = st_n.ka_sent + 32'd1;
				end
				if (item.op == OP_ENSURE && st.mode == MODE_ASLEEP) begin
					st_n.mode = MODE_WAKE_REQ;
					st_n.mode_entry = now;
					st_n.attempts = st_n.attempts + 32'd1;
				end
			end
			OP_REQUEST: begin
				if (st.mode == MODE_ASLEEP || st.mode == MODE_WAKE_REQ) begin
					if (st.mode != MODE_WAKE_REQ) begin
						st_n.mode = MODE_WAKE_REQ;
						st_n.mode_entry = now;
					end
					st_n.last_cmd_time = now;
					st_n.attempts = st_n.attempts + 32'd1;
				end
			end
		endcase
		run.kinds = kinds;
		run.len   = (cnt == 2'd0) ? 2'd1 : cnt;
	end

endmodule

[design/vehicle_wake_keepalive_fsm.sv]
// Vehicle bus wake controller with keep-alive: top level.
//
// Events enter on in_valid/in_stall carrying op, now_ms, bus_activity and
// transmit status. Each event produces a run of one to three results on
// out_valid/out_stall; frame_kind names the frame sent (or none) and
// last_of_run marks the final transfer of the run. Every result of a run
// shows the status and counters after the whole event.
// An event is registered on acceptance, evaluated combinationally from
// that register, and its results are registered once the output is free.
// Throughput is one result per cycle while out_stall is low; a run of
// several results holds the output register until its last is taken.
// The next event is taken while a run is still waiting to be taken.
// When the receiver stalls, the result register holds and the input stage
// stalls once it is full. Configuration writes (cfg_valid/cfg_ready) are
// always taken and should only occur while the block is idle.
// Reset puts the controller asleep with all counters and timestamps at zero
// and the timing registers at their defaults.
module vehicle_wake_keepalive_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  vwk_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output vwk_pkg::out_item_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import vwk_pkg::*;

	cfg_regs_t   cfg_q;
	wake_state_t st_q;
	wake_state_t st_n;
	run_t        run_n;

	in_item_t    item_s1;
	logic        valid_s1;

	run_t        run_q;
	logic [1:0]  idx_q;
	logic        out_valid_q;
	logic [1:0]  rstat_mode_q;
	logic        rstat_ka_q;
	logic [31:0] rstat_att_q;
	logic [31:0] rstat_fail_q;
	logic [31:0] rstat_kas_q;

	logic last_res;
	logic out_xfer;
	logic adv_s1;
	logic in_xfer;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ka_interval <= 16'd500;
			cfg_q.ka_timeout  <= 32'd300000;
			cfg_q.wake_limit  <= 32'd5000;
			cfg_q.init_wait   <= 32'd1000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KA_INTERVAL: cfg_q.ka_interval <= cfg_data[15:0];
				REG_KA_TIMEOUT:  cfg_q.ka_timeout  <= cfg_data;
				REG_WAKE_LIMIT:  cfg_q.wake_limit  <= cfg_data;
				REG_INIT_WAIT:   cfg_q.init_wait   <= cfg_data;
			endcase
		end
	end

	vwk_step u_step (
		.st   (st_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.st_n (st_n),
		.run  (run_n)
	);

	assign last_res = (idx_q == run_q.len - 2'd1);
	assign out_xfer = out_valid_q && !out_stall;
	assign adv_s1   = valid_s1 && (!out_valid_q || (out_xfer && last_res));
	assign in_stall = valid_s1 && !adv_s1;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			st_q        <= '0;
		end else begin
			if (in_xfer)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;

			if (adv_s1) begin
				st_q        <= st_n;
				out_valid_q <= 1'b1;
				idx_q       <= 2'd0;
			end else if (out_xfer) begin
				if (last_res)
					out_valid_q <= 1'b0;
				else
					idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			item_s1 <= in_data;
		if (adv_s1) begin
			run_q        <= run_n;
			rstat_mode_q <= st_n.mode;
			rstat_ka_q   <= st_n.ka_active;
			rstat_att_q  <= st_n.attempts;
			rstat_fail_q <= st_n.failures;
			rstat_kas_q  <= st_n.ka_sent;
		end
	end

	assign out_valid                = out_valid_q;
	assign out_data.frame_kind      = run_q.kinds[idx_q];
	assign out_data.last_of_run     = last_res;
	assign out_data.wake_status     = rstat_mode_q;
	assign out_data.keepalive_on    = rstat_ka_q;
	assign out_data.attempt_count   = rstat_att_q;
	assign out_data.failure_count   = rstat_fail_q;
	assign out_data.keepalive_count = rstat_kas_q;

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (idx_q < run_q.len))
		else $error("result index beyond run length");

	a_none_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data.frame_kind == FRAME_NONE) |-> (run_q.len == 2'd1))
		else $error("empty frame inside a multi-result run");

	a_fail_step: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.failures != $past(st_q.failures)) |->
			(st_q.failures == $past(st_q.failures) + 32'd1))
		else $error("failure count moved by more than one");

	a_waking_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.mode == MODE_WAKING && $past(st_q.mode) != MODE_WAKING) |->
			($past(st_q.mode) == MODE_WAKE_REQ))
		else $error("waking entered from a state other than wake requested");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		(in_stall && !out_stall) |-> (out_valid_q && !last_res))
		else $error("input stalled while output can drain");

endmodule
